>>> hw/rtl/dstg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// decaying sine tone generator. No dependencies; every other file imports it.
package dstg_pkg;

  localparam int unsigned AUDIO_RATE       = 44100;
  localparam int unsigned NOTE_SECONDS     = 10;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_BITS       = 32;
  localparam int unsigned SINE_DEPTH_MAX   = 4096;

  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AMP_W    = 18;
  localparam int unsigned MAG_W    = 15;

  localparam logic [AMP_W-1:0] FULL_AMP   = AMP_W'(163800);
  localparam int unsigned      AMP_DIV    = 5 * 32767;
  localparam int               SAMPLE_MAX = 32760;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [FREQ_W-1:0] note_freq_hz;
  } dstg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
  } dstg_out_t;

  typedef struct packed {
    logic vld;
    logic play;
    logic neg;
    logic active;
  } dstg_ctl_t;

  typedef logic [SINE_DEPTH_MAX:0][MAG_W-1:0] qtab_t;

  // Builds sin(pi/2 * k / depth) in Q15 from an integer Taylor series in Q30.
  function automatic qtab_t dstg_build_qtab(input int unsigned depth_bits);
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    int unsigned depth;
    tab   = '0;
    depth = 1 << depth_bits;
    for (int unsigned k = 0; k <= depth; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> depth_bits;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 9; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'(TAYLOR_DIV[n]);
        if (n[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[MAG_W-1:0];
    end
    return tab;
  endfunction

endpackage

>>> hw/rtl/decaying_sine_tone_generator.sv
// Top level of the decaying sine tone generator: input register, voice state,
// sample pipeline and output register. Uses dstg_pkg and the dstg_* submodules.
//
// The input channel carries one command per transaction: tick, start or stop.
// Every input transaction produces exactly one output transaction holding a
// signed sample and the voice activity flag, in order.
// From input acceptance to the output becoming valid, a command passes the input
// register, sine ROM read, amplitude product, reciprocal quotient and output register.
// Ticks and stops are taken one per cycle while the receiver does not stall.
// A start loads the phase step through a three-stage divider, so the input
// channel stalls while the start is in the input register and while the divider's
// first stage is busy; the step register is written before the next command reaches the voice state.
// When the receiver stalls, the whole pipeline holds and the input stall
// rises as soon as the input register is occupied.
// Reset clears the voice (inactive, zero phase, step, amplitude and note
// count) and empties the pipeline; no output transaction is pending after it.
module decaying_sine_tone_generator
  import dstg_pkg::*;
#(
  parameter int unsigned AudioRate      = AUDIO_RATE,
  parameter int unsigned NoteSeconds    = NOTE_SECONDS,
  parameter int unsigned SineTableDepth = SINE_TABLE_DEPTH,
  parameter int unsigned PhaseBits      = PHASE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dstg_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dstg_out_t out_data_o
);

  localparam int unsigned NOTE_LEN = AudioRate * NoteSeconds;
  localparam int unsigned SL_W     = $clog2(NOTE_LEN + 1);
  localparam int unsigned DB       = $clog2(SineTableDepth);
  localparam int unsigned AW       = DB + 1;

  logic                 en, accept, proc, busy, is_start;
  logic                 in_vld_q;
  dstg_in_t             in_q;

  logic [PhaseBits-1:0] phase_acc_d, phase_acc_q;
  logic [PhaseBits-1:0] phase_step;
  logic [AMP_W-1:0]     amp_d, amp_q;
  logic [SL_W-1:0]      sl_d, sl_q, sl_dec;
  logic                 voice_d, voice_q;
  logic                 div_busy;

  dstg_ctl_t            ctl_a_d, ctl_a_q, ctl_c;
  logic [AMP_W-1:0]     amp_a_q;
  logic [DB-1:0]        rom_r;
  logic [AW-1:0]        rom_addr;
  logic [MAG_W-1:0]     rom_data;
  logic signed [SAMPLE_W-1:0] sample_c;

  logic                 out_vld_q;
  dstg_out_t            out_q;

  assign en       = !out_vld_q || !out_stall_i;
  assign is_start = in_q.opcode == OP_START;
  assign busy     = (in_vld_q && is_start) || div_busy;
  assign in_stall_o = (in_vld_q && !en) || busy;
  assign accept   = in_valid_i && !in_stall_o;
  assign proc     = in_vld_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  dstg_step_div #(
    .AudioRate(AudioRate),
    .PhaseBits(PhaseBits)
  ) u_step_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(proc && is_start),
    .freq_i (in_q.note_freq_hz),
    .busy_o (div_busy),
    .step_o (phase_step)
  );

  assign sl_dec = (sl_q != '0) ? sl_q - SL_W'(1) : sl_q;

  always_comb begin
    phase_acc_d = phase_acc_q;
    amp_d       = amp_q;
    sl_d        = sl_q;
    voice_d     = voice_q;
    unique case (in_q.opcode)
      OP_START: begin
        phase_acc_d = '0;
        amp_d       = FULL_AMP;
        sl_d        = SL_W'(NOTE_LEN);
        voice_d     = 1'b1;
      end
      OP_STOP: begin
        voice_d = 1'b0;
      end
      OP_TICK: begin
        if (voice_q) begin
          phase_acc_d = phase_acc_q + phase_step;
          amp_d       = (amp_q != '0) ? amp_q - AMP_W'(1) : amp_q;
          sl_d        = sl_dec;
          voice_d     = sl_dec != '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      amp_q       <= '0;
      sl_q        <= '0;
      voice_q     <= 1'b0;
    end else if (proc) begin
      phase_acc_q <= phase_acc_d;
      amp_q       <= amp_d;
      sl_q        <= sl_d;
      voice_q     <= voice_d;
    end
  end

  assign rom_r    = phase_acc_q[PhaseBits-3 -: DB];
  assign rom_addr = phase_acc_q[PhaseBits-2] ? AW'(SineTableDepth) - AW'(rom_r) : AW'(rom_r);

  assign ctl_a_d.vld    = in_vld_q;
  assign ctl_a_d.play   = (in_q.opcode == OP_TICK) && voice_q;
  assign ctl_a_d.neg    = phase_acc_q[PhaseBits-1];
  assign ctl_a_d.active = voice_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (en) begin
      ctl_a_q <= ctl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      amp_a_q <= amp_q;
    end
  end

  dstg_sine_rom #(
    .SineTableDepth(SineTableDepth)
  ) u_sine_rom (
    .clk_i (clk_i),
    .en_i  (en),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  dstg_amp_scale u_amp_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_a_q),
    .amp_i   (amp_a_q),
    .mag_i   (rom_data),
    .ctl_o   (ctl_c),
    .sample_o(sample_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_c.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.sample <= ctl_c.play ? sample_c : '0;
      out_q.active <= ctl_c.active;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) div_busy |-> in_stall_o)
    else $error("Input was not stalled while the phase step was being computed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (proc && is_start) |=> (voice_q && phase_acc_q == '0 && amp_q == FULL_AMP))
    else $error("A start did not reload the voice state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) amp_q <= FULL_AMP)
    else $error("Amplitude exceeded full scale.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (int'(out_data_o.sample) <= SAMPLE_MAX &&
                       int'(out_data_o.sample) >= -SAMPLE_MAX))
    else $error("Output sample is outside the amplitude range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (proc && in_q.opcode == OP_STOP) |=> !voice_q)
    else $error("A stop left the voice active.");

endmodule

>>> hw/rtl/dstg_step_div.sv
// Phase step unit: round(freq * 2^PhaseBits / AudioRate) in three stages.
// Uses a quotient split plus a reciprocal multiply with one correction; imports dstg_pkg.
module dstg_step_div
  import dstg_pkg::*;
#(
  parameter int unsigned AudioRate = AUDIO_RATE,
  parameter int unsigned PhaseBits = PHASE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FREQ_W-1:0]    freq_i,
  output logic                 busy_o,
  output logic [PhaseBits-1:0] step_o
);

  localparam logic [63:0] SR64   = 64'(AudioRate);
  localparam logic [63:0] STEP_Q = (64'd1 << PhaseBits) / SR64;
  localparam logic [63:0] STEP_R = (64'd1 << PhaseBits) % SR64;
  localparam int unsigned MW     = $clog2(SR64 << FREQ_W);
  localparam logic [63:0] RECIP  = (64'd1 << MW) / SR64;
  localparam int unsigned RW     = $clog2(RECIP + 64'd1);
  localparam int unsigned QW     = FREQ_W + 1;

  logic                 s1_vld_q, s2_vld_q;
  logic [MW-1:0]        m1_d, m1_q, m2_q;
  logic [PhaseBits-1:0] aq1_d, aq1_q, aq2_q;
  logic [MW+RW-1:0]     qprod;
  logic [QW-1:0]        qh2_q;
  logic [MW-1:0]        rem;
  logic [PhaseBits-1:0] step_d, step_q;

  assign m1_d  = MW'(freq_i) * MW'(STEP_R) + MW'(SR64 >> 1);
  assign aq1_d = PhaseBits'(freq_i) * PhaseBits'(STEP_Q);
  assign qprod = (MW + RW)'(m1_q) * (MW + RW)'(RECIP);
  assign rem   = m2_q - MW'(qh2_q) * MW'(SR64);
  assign step_d = aq2_q + PhaseBits'(qh2_q) + PhaseBits'(rem >= MW'(SR64));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      step_q   <= '0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        step_q <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m1_q  <= m1_d;
      aq1_q <= aq1_d;
    end
    m2_q  <= m1_q;
    aq2_q <= aq1_q;
    qh2_q <= qprod[MW +: QW];
  end

  assign busy_o = s1_vld_q;
  assign step_o = step_q;

endmodule

>>> hw/rtl/dstg_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
// Contents are built at elaboration by the table function in dstg_pkg.
module dstg_sine_rom
  import dstg_pkg::*;
#(
  parameter int unsigned SineTableDepth = SINE_TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [$clog2(SineTableDepth):0]      addr_i,
  output logic [MAG_W-1:0]                     data_o
);

  localparam int unsigned DB   = $clog2(SineTableDepth);
  localparam qtab_t       QTAB = dstg_build_qtab(DB);

  logic [MAG_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= QTAB[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/dstg_amp_scale.sv
// Amplitude scaling pipeline: amp_fifths * |sin| / 163835, truncated, with sign.
// Two register stages plus a final correction step; imports dstg_pkg.
module dstg_amp_scale
  import dstg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  dstg_ctl_t                  ctl_i,
  input  logic [AMP_W-1:0]           amp_i,
  input  logic [MAG_W-1:0]           mag_i,
  output dstg_ctl_t                  ctl_o,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int unsigned PW     = AMP_W + MAG_W;
  localparam logic [63:0] RECIP  = (64'd1 << PW) / 64'(AMP_DIV);
  localparam int unsigned RW     = $clog2(RECIP + 64'd1);

  dstg_ctl_t             ctl_b_q, ctl_c_q;
  logic [PW-1:0]         prod_b_q, prod_c_q;
  logic [PW+RW-1:0]      qprod;
  logic [SAMPLE_W-1:0]   qh_c_q;
  logic [PW-1:0]         rem;
  logic [SAMPLE_W-1:0]   mag_v;

  assign qprod = (PW + RW)'(prod_b_q) * (PW + RW)'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= ctl_i;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_b_q <= PW'(amp_i) * PW'(mag_i);
      prod_c_q <= prod_b_q;
      qh_c_q   <= qprod[PW +: SAMPLE_W];
    end
  end

  assign rem      = prod_c_q - PW'(qh_c_q) * PW'(AMP_DIV);
  assign mag_v    = qh_c_q + SAMPLE_W'(rem >= PW'(AMP_DIV));
  assign sample_o = ctl_c_q.neg ? -$signed(mag_v) : $signed(mag_v);
  assign ctl_o    = ctl_c_q;

endmodule
